FILE: src/scp_pkg.sv
// Shared types, widths and constants for the scan polar-to-cartesian converter.
`timescale 1ns / 1ps

package scp_pkg;

  localparam int XW = 35;
  localparam int ZW = 33;
  localparam int CW = 17;
  localparam int ATAN_ENTRIES = 24;
  localparam logic [31:0] GAIN_Q32 = 32'd2608131496;

  localparam logic [2:0] REG_START_ANGLE = 3'd0;
  localparam logic [2:0] REG_ANGLE_STEP  = 3'd4;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 invalid;
    logic                 last;
  } scp_vec_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 valid;
    logic                 last;
  } scp_point_t;

  function automatic logic signed [ZW-1:0] scp_atan(input int unsigned k);
    logic signed [ZW-1:0] a;
    case (k)
      0:       a = 33'sh020000000;
      1:       a = 33'sh012E4051E;
      2:       a = 33'sh009FB385B;
      3:       a = 33'sh0051111D4;
      4:       a = 33'sh0028B0D43;
      5:       a = 33'sh00145D7E1;
      6:       a = 33'sh000A2F61E;
      7:       a = 33'sh000517C55;
      8:       a = 33'sh00028BE53;
      9:       a = 33'sh000145F2F;
      10:      a = 33'sh0000A2F98;
      11:      a = 33'sh0000517CC;
      12:      a = 33'sh000028BE6;
      13:      a = 33'sh0000145F3;
      14:      a = 33'sh00000A2FA;
      15:      a = 33'sh00000517D;
      16:      a = 33'sh0000028BE;
      17:      a = 33'sh00000145F;
      18:      a = 33'sh000000A30;
      19:      a = 33'sh000000518;
      20:      a = 33'sh00000028C;
      21:      a = 33'sh000000146;
      22:      a = 33'sh0000000A3;
      23:      a = 33'sh000000051;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

FILE: src/scp_phase.sv
// Sample angle computation, quadrant fold and gain-scaled start vector.
`timescale 1ns / 1ps

module scp_phase import scp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_v,
  input  logic [15:0] range_value,
  input  logic        range_invalid,
  input  logic [11:0] sample_index,
  input  logic        last_of_scan,
  input  logic [15:0] start_angle,
  input  logic [15:0] angle_step,
  output logic        out_v,
  output scp_vec_t    out_vec
);

  logic        s1_v_r, s1_v_nxt;
  logic [15:0] s1_prod_r, s1_prod_nxt;
  logic [15:0] s1_range_r;
  logic        s1_inv_r, s1_last_r;

  logic        s2_v_r, s2_v_nxt;
  logic [47:0] s2_gmul_r, s2_gmul_nxt;
  logic        s2_neg_r, s2_neg_nxt;
  logic [15:0] s2_resid_r, s2_resid_nxt;
  logic        s2_inv_r, s2_last_r;

  logic        s3_v_r, s3_v_nxt;
  scp_vec_t    s3_vec_r, s3_vec_nxt;

  logic [27:0] prod;
  logic [15:0] phase;
  logic [48:0] gsum;
  logic [XW-1:0] xext;

  always_comb begin
    prod        = {16'd0, sample_index} * {12'd0, angle_step};
    s1_prod_nxt = prod[15:0];
    s1_v_nxt    = in_v;

    phase        = start_angle + s1_prod_r;
    s2_neg_nxt   = phase[15] ^ phase[14];
    s2_resid_nxt = {phase[15] ^ s2_neg_nxt, phase[14:0]};
    s2_gmul_nxt  = {32'd0, s1_range_r} * {16'd0, GAIN_Q32};
    s2_v_nxt     = s1_v_r;

    gsum = {1'b0, s2_gmul_r} + 49'h0_0000_0000_8000;
    xext = {2'b00, gsum[48:16]};
    s3_vec_nxt.x       = s2_neg_r ? (~xext + XW'(1)) : xext;
    s3_vec_nxt.y       = '0;
    s3_vec_nxt.z       = {{(ZW-32){s2_resid_r[15]}}, s2_resid_r, 16'h0000};
    s3_vec_nxt.invalid = s2_inv_r;
    s3_vec_nxt.last    = s2_last_r;
    s3_v_nxt           = s2_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
      s3_v_r <= s3_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_prod_r  <= s1_prod_nxt;
      s1_range_r <= range_value;
      s1_inv_r   <= range_invalid;
      s1_last_r  <= last_of_scan;
      s2_gmul_r  <= s2_gmul_nxt;
      s2_neg_r   <= s2_neg_nxt;
      s2_resid_r <= s2_resid_nxt;
      s2_inv_r   <= s1_inv_r;
      s2_last_r  <= s1_last_r;
      s3_vec_r   <= s3_vec_nxt;
    end
  end

  assign out_v   = s3_v_r;
  assign out_vec = s3_vec_r;

endmodule

FILE: src/scp_cordic_stage.sv
// One registered micro-rotation of the CORDIC pipeline.
`timescale 1ns / 1ps

module scp_cordic_stage import scp_pkg::*; #(
  parameter int SHIFT = 0
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  logic     in_v,
  input  scp_vec_t in_vec,
  output logic     out_v,
  output scp_vec_t out_vec
);

  localparam logic signed [ZW-1:0] ATAN = scp_atan(SHIFT);

  logic            v_r, v_nxt;
  scp_vec_t        vec_r, vec_nxt;
  logic signed [XW-1:0] xi, yi, dx, dy;
  logic signed [ZW-1:0] zi;

  always_comb begin
    xi = in_vec.x;
    yi = in_vec.y;
    zi = in_vec.z;
    dx = yi >>> SHIFT;
    dy = xi >>> SHIFT;
    vec_nxt = in_vec;
    if (!zi[ZW-1]) begin
      vec_nxt.x = xi - dx;
      vec_nxt.y = yi + dy;
      vec_nxt.z = zi - ATAN;
    end else begin
      vec_nxt.x = xi + dx;
      vec_nxt.y = yi - dy;
      vec_nxt.z = zi + ATAN;
    end
    v_nxt = in_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r <= vec_nxt;
    end
  end

  assign out_v   = v_r;
  assign out_vec = vec_r;

endmodule

FILE: src/scp_output.sv
// Output rounding and saturation stage with a skid register toward the result channel.
`timescale 1ns / 1ps

module scp_output import scp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_v,
  input  scp_vec_t   in_vec,
  input  logic       out_ready,
  output logic       en,
  output logic       out_v,
  output scp_point_t out_pt
);

  logic       rnd_v_r, rnd_v_nxt;
  scp_point_t rnd_r, rnd_nxt;
  logic       out_v_r, out_v_nxt;
  scp_point_t out_r, out_nxt;
  logic       skid_v_r, skid_v_nxt;
  scp_point_t skid_r, skid_nxt;
  logic       push, pop;

  function automatic logic signed [CW-1:0] round_sat(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] r;
    logic signed [CW-1:0] o;
    r = (v + XW'(32768)) >>> 16;
    if (r > XW'(65535)) begin
      o = 17'sd65535;
    end else if (r < -XW'(65535)) begin
      o = -17'sd65535;
    end else begin
      o = r[CW-1:0];
    end
    return o;
  endfunction

  assign en = !skid_v_r;

  always_comb begin
    rnd_v_nxt     = in_v;
    rnd_nxt.valid = !in_vec.invalid;
    rnd_nxt.last  = in_vec.last;
    rnd_nxt.x     = in_vec.invalid ? '0 : round_sat(in_vec.x);
    rnd_nxt.y     = in_vec.invalid ? '0 : round_sat(in_vec.y);

    push       = en && rnd_v_r;
    pop        = out_v_r && out_ready;
    out_v_nxt  = out_v_r;
    out_nxt    = out_r;
    skid_v_nxt = skid_v_r;
    skid_nxt   = skid_r;
    if (skid_v_r) begin
      if (pop) begin
        out_nxt    = skid_r;
        skid_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_v_r || pop) begin
        out_nxt   = rnd_r;
        out_v_nxt = 1'b1;
      end else begin
        skid_nxt   = rnd_r;
        skid_v_nxt = 1'b1;
      end
    end else if (pop) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_v_r  <= 1'b0;
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (en) begin
        rnd_v_r <= rnd_v_nxt;
      end
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rnd_r <= rnd_nxt;
    end
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_v  = out_v_r;
  assign out_pt = out_r;

endmodule

FILE: src/scan_polar_to_cartesian.sv
// Top level of the laser scan polar-to-cartesian converter.
`timescale 1ns / 1ps

// Each input transaction carries one range sample; its angle is start_angle plus
// sample_index times angle_step in phase units of 65536 per turn, and a gain-compensated
// CORDIC turns it into x and y in the range units, rounded and saturated to +/-65535.
// Invalid samples give zero coordinates with tuser low. The block takes one transaction
// every clock cycle unless the input is stalled; out_tvalid for a result rises after its
// input has passed three angle and gain stages, one register per CORDIC stage (at most
// 24 are used), a rounding stage and the output register. A skid register at the
// output lets in_tready come from a flip-flop; the input stalls only while that register
// holds a result. Registers: start_angle at byte address 0, angle_step at 4.

module scan_polar_to_cartesian import scp_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // range_value[15:0], sample_index[27:16], zero pad
  input  logic        in_tuser,   // range_invalid
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // point_x[16:0], point_y[33:17], zero pad
  output logic        out_tuser,  // point_valid
  output logic        out_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NST = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;

  logic [15:0] start_angle_r, start_angle_nxt;
  logic [15:0] angle_step_r, angle_step_nxt;
  logic        en;
  logic        wr;
  logic        chain_v [NST+1];
  scp_vec_t    chain_vec [NST+1];
  scp_point_t  pt;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_comb begin
    start_angle_nxt = start_angle_r;
    angle_step_nxt  = angle_step_r;
    if (wr) begin
      if (paddr[2] == REG_ANGLE_STEP[2]) begin
        angle_step_nxt = pwdata[15:0];
      end else begin
        start_angle_nxt = pwdata[15:0];
      end
    end
    if (paddr[2] == REG_ANGLE_STEP[2]) begin
      prdata = {{16{angle_step_r[15]}}, angle_step_r};
    end else begin
      prdata = {{16{start_angle_r[15]}}, start_angle_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_angle_r <= '0;
      angle_step_r  <= '0;
    end else begin
      start_angle_r <= start_angle_nxt;
      angle_step_r  <= angle_step_nxt;
    end
  end

  assign in_tready = en;

  scp_phase u_phase (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .in_v          (in_tvalid && en),
    .range_value   (in_tdata[15:0]),
    .range_invalid (in_tuser),
    .sample_index  (in_tdata[27:16]),
    .last_of_scan  (in_tlast),
    .start_angle   (start_angle_r),
    .angle_step    (angle_step_r),
    .out_v         (chain_v[0]),
    .out_vec       (chain_vec[0])
  );

  for (genvar g = 0; g < NST; g++) begin : g_cordic
    scp_cordic_stage #(.SHIFT(g)) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_v    (chain_v[g]),
      .in_vec  (chain_vec[g]),
      .out_v   (chain_v[g+1]),
      .out_vec (chain_vec[g+1])
    );
  end

  scp_output u_output (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_v      (chain_v[NST]),
    .in_vec    (chain_vec[NST]),
    .out_ready (out_tready),
    .en        (en),
    .out_v     (out_tvalid),
    .out_pt    (pt)
  );

  assign out_tdata = {6'd0, pt.y, pt.x};
  assign out_tuser = pt.valid;
  assign out_tlast = pt.last;

`ifndef SYNTHESIS
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[33:0] == 34'd0)
    else $error("invalid sample produced nonzero coordinates");

  a_x_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[16:0] != 17'h10000 && out_tdata[33:17] != 17'h10000)
    else $error("coordinate outside the saturation limit");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(out_tvalid && !out_tready))
    else $error("input stalled without output back pressure");

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr && paddr[2] == REG_START_ANGLE[2] |=> start_angle_r == $past(pwdata[15:0]))
    else $error("start angle register write lost");
`endif

endmodule
